// ===== hdl/assert_macros.svh =====
// Assertion macros used by the block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/umcs_pkg.sv =====
// Types and constants of the USART mode, command and status block.
`timescale 1ns / 1ps

package umcs_pkg;

	localparam int NOW_W  = 63;
	localparam int BT_W   = 32;
	localparam int BYTE_W = 8;

	// base character length; length code adds to it
	localparam logic [3:0] CHAR_LEN_BASE = 4'd5;

	// access codes
	typedef enum logic [2:0] {
		MODE_CTRL_WR = 3'd0,
		MODE_STAT_RD = 3'd1,
		MODE_DATA_WR = 3'd2,
		MODE_DATA_RD = 3'd3,
		MODE_TICK    = 3'd4,
		MODE_PEEK    = 3'd5
	} mode_t;

	// command byte bits
	localparam int CMD_TXEN  = 0;
	localparam int CMD_DTR   = 1;
	localparam int CMD_RXEN  = 2;
	localparam int CMD_BRK   = 3;
	localparam int CMD_RTS   = 5;
	localparam int CMD_IRST  = 6;

	// reset values of the mode fields
	localparam logic [1:0] BAUD_RST = 2'd3;
	localparam logic [1:0] STOP_RST = 2'd1;
	localparam logic [1:0] LEN_RST  = 2'd3;
	localparam logic [1:0] BAUD_SYNC = 2'd0;

	typedef struct packed {
		logic [2:0]        mode;
		logic [BYTE_W-1:0] data_byte;
		logic [NOW_W-1:0]  now_time;
		logic              client_rx_ready;
		logic              client_tx_ready;
		logic              client_dsr;
		logic [BYTE_W-1:0] client_rx_byte;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              rts_level;
		logic              dtr_level;
		logic              break_level;
		logic [3:0]        char_length;
		logic              parity_enable;
		logic              even_parity;
		logic [1:0]        stop_bits_code;
		logic [1:0]        baud_factor_code;
	} out_t;

endpackage

// ===== hdl/umcs_expiry.sv =====
// Byte-time expiry compare: last transfer time plus byte time against now.
`timescale 1ns / 1ps

module umcs_expiry (
	input  logic [umcs_pkg::NOW_W-1:0] last_time,
	input  logic [umcs_pkg::BT_W-1:0]  byte_time,
	input  logic [umcs_pkg::NOW_W-1:0] now_time,
	output logic                       expired
);
	import umcs_pkg::*;

	logic [NOW_W:0] deadline;

	// one bit of headroom: the sum cannot wrap
	assign deadline = {1'b0, last_time} + {{(NOW_W + 1 - BT_W){1'b0}}, byte_time};
	assign expired  = deadline < {1'b0, now_time};

endmodule

// ===== hdl/usart_mode_command_status.sv =====
// Top level of the USART mode, command and status register block.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Register model of an 8251-style USART. Each input word is one access
// (control write, status read, data write, data read, time tick or data
// peek) and gives exactly one output word, in order. The first control
// write after reset, or after an internal reset command, is the mode byte;
// later ones are commands. The byte time must be written on the cfg channel
// only while the block is idle; the block itself does not enforce this. It
// survives internal reset. Throughput is one word per clock while out_ready
// does not stall the output. An accepted word passes from the input register
// through the single decode stage, whose longest path is the 64-bit add and
// compare of the tick, to the output register. No clearing pass is needed after reset.

module usart_mode_command_status (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  umcs_pkg::in_t                in_word,
	output logic                         out_valid,
	input  logic                         out_ready,
	output umcs_pkg::out_t               out_word,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [umcs_pkg::BT_W-1:0]    cfg_data
);
	import umcs_pkg::*;

	// input stage
	logic  in_valid_s1;
	in_t   in_word_s1;

	// output stage
	logic  out_valid_s2;
	out_t  out_word_s2;

	// configuration
	logic [BT_W-1:0] byte_time_q;

	// register state
	logic             awaiting_mode_q;
	logic [1:0]       baud_q, stop_q, len_q;
	logic             par_on_q, par_even_q;
	logic             txen_q, dtr_q, rxen_q, brk_q, rts_q;
	logic             txrdy_q, rxrdy_q, txempty_q;
	logic [NOW_W-1:0] last_tx_q, last_rx_q;

	// next state
	logic             awaiting_mode_d;
	logic [1:0]       baud_d, stop_d, len_d;
	logic             par_on_d, par_even_d;
	logic             txen_d, dtr_d, rxen_d, brk_d, rts_d;
	logic             txrdy_d, rxrdy_d, txempty_d;
	logic [NOW_W-1:0] last_tx_d, last_rx_d;
	out_t             out_d;

	logic advance;
	logic tx_expired, rx_expired;

	// s1 moves on whenever the output slot is free or being drained
	assign advance   = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = out_valid_s2;
	assign out_word  = out_word_s2;
	assign cfg_ready = 1'b1;

	umcs_expiry u_tx_expiry (
		.last_time (last_tx_q),
		.byte_time (byte_time_q),
		.now_time  (in_word_s1.now_time),
		.expired   (tx_expired)
	);

	umcs_expiry u_rx_expiry (
		.last_time (last_rx_q),
		.byte_time (byte_time_q),
		.now_time  (in_word_s1.now_time),
		.expired   (rx_expired)
	);

	always_comb begin
		awaiting_mode_d = awaiting_mode_q;
		baud_d          = baud_q;
		stop_d          = stop_q;
		len_d           = len_q;
		par_on_d        = par_on_q;
		par_even_d      = par_even_q;
		txen_d          = txen_q;
		dtr_d           = dtr_q;
		rxen_d          = rxen_q;
		brk_d           = brk_q;
		rts_d           = rts_q;
		txrdy_d         = txrdy_q;
		rxrdy_d         = rxrdy_q;
		txempty_d       = txempty_q;
		last_tx_d       = last_tx_q;
		last_rx_d       = last_rx_q;
		out_d           = '0;

		unique case (in_word_s1.mode)
			MODE_CTRL_WR: begin
				if (awaiting_mode_q) begin
					// mode byte
					awaiting_mode_d = 1'b0;
					baud_d          = in_word_s1.data_byte[1:0];
					len_d           = in_word_s1.data_byte[3:2];
					par_on_d        = in_word_s1.data_byte[4];
					par_even_d      = in_word_s1.data_byte[5];
					// sync mode keeps the stop code
					if (in_word_s1.data_byte[1:0] != BAUD_SYNC) begin
						stop_d = in_word_s1.data_byte[7:6];
					end
				end else if (in_word_s1.data_byte[CMD_IRST]) begin
					// internal reset: everything but the byte time
					awaiting_mode_d = 1'b1;
					baud_d          = BAUD_RST;
					stop_d          = STOP_RST;
					len_d           = LEN_RST;
					par_on_d        = 1'b0;
					par_even_d      = 1'b1;
					txen_d          = 1'b0;
					dtr_d           = 1'b0;
					rxen_d          = 1'b0;
					brk_d           = 1'b0;
					rts_d           = 1'b0;
					txrdy_d         = 1'b0;
					rxrdy_d         = 1'b0;
					txempty_d       = 1'b0;
					last_tx_d       = '0;
					last_rx_d       = '0;
				end else begin
					// command byte; error reset bit has nothing to clear
					txen_d = in_word_s1.data_byte[CMD_TXEN];
					dtr_d  = in_word_s1.data_byte[CMD_DTR];
					rxen_d = in_word_s1.data_byte[CMD_RXEN];
					brk_d  = in_word_s1.data_byte[CMD_BRK];
					rts_d  = in_word_s1.data_byte[CMD_RTS];
				end
			end
			MODE_STAT_RD: begin
				// error and sync flags never set
				out_d.read_data = {in_word_s1.client_dsr, 4'b0000, txempty_q,
					rxrdy_q && in_word_s1.client_rx_ready,
					txrdy_q && in_word_s1.client_tx_ready};
			end
			MODE_DATA_WR: begin
				last_tx_d      = in_word_s1.now_time;
				txrdy_d        = 1'b0;
				txempty_d      = 1'b0;
				out_d.tx_valid = 1'b1;
				out_d.tx_byte  = in_word_s1.data_byte;
			end
			MODE_DATA_RD: begin
				last_rx_d       = in_word_s1.now_time;
				rxrdy_d         = 1'b0;
				out_d.read_data = in_word_s1.client_rx_byte;
			end
			MODE_TICK: begin
				if (txen_q && tx_expired) begin
					txrdy_d   = 1'b1;
					txempty_d = 1'b1;
				end
				if (rxen_q && rx_expired) begin
					rxrdy_d = 1'b1;
				end
			end
			MODE_PEEK: begin
				out_d.read_data = in_word_s1.client_rx_byte;
			end
			default: begin
			end
		endcase

		// status outputs reflect the state after this access
		out_d.rts_level        = rts_d;
		out_d.dtr_level        = dtr_d;
		out_d.break_level      = brk_d;
		out_d.char_length      = CHAR_LEN_BASE + {2'b00, len_d};
		out_d.parity_enable    = par_on_d;
		out_d.even_parity      = par_even_d;
		out_d.stop_bits_code   = stop_d;
		out_d.baud_factor_code = baud_d;
	end

	// handshake stages and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
			byte_time_q  <= '0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
			if (cfg_valid) begin
				byte_time_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_word_s1 <= in_word;
		end
		if (advance) begin
			out_word_s2 <= out_d;
		end
	end

	// USART state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_mode_q <= 1'b1;
			baud_q          <= BAUD_RST;
			stop_q          <= STOP_RST;
			len_q           <= LEN_RST;
			par_on_q        <= 1'b0;
			par_even_q      <= 1'b1;
			txen_q          <= 1'b0;
			dtr_q           <= 1'b0;
			rxen_q          <= 1'b0;
			brk_q           <= 1'b0;
			rts_q           <= 1'b0;
			txrdy_q         <= 1'b0;
			rxrdy_q         <= 1'b0;
			txempty_q       <= 1'b0;
			last_tx_q       <= '0;
			last_rx_q       <= '0;
		end else if (advance) begin
			awaiting_mode_q <= awaiting_mode_d;
			baud_q          <= baud_d;
			stop_q          <= stop_d;
			len_q           <= len_d;
			par_on_q        <= par_on_d;
			par_even_q      <= par_even_d;
			txen_q          <= txen_d;
			dtr_q           <= dtr_d;
			rxen_q          <= rxen_d;
			brk_q           <= brk_d;
			rts_q           <= rts_d;
			txrdy_q         <= txrdy_d;
			rxrdy_q         <= rxrdy_d;
			txempty_q       <= txempty_d;
			last_tx_q       <= last_tx_d;
			last_rx_q       <= last_rx_d;
		end
	end

	// TxRDY and TxEMPTY move together in this model
	`ASSERT_CLK(a_tx_flags_pair, clk, arst_n, txrdy_q == txempty_q, "TxRDY and TxEMPTY differ")

	// a word in s1 with a free output slot must reach the output
	`ASSERT_CLK(a_s1_drains, clk, arst_n, in_valid_s1 && !out_valid_s2 |=> out_valid_s2, "s1 word not moved to output")

	// a data write clears the transmit ready flags
	`ASSERT_CLK(a_wr_clears_tx, clk, arst_n, advance && in_word_s1.mode == MODE_DATA_WR |=> !txrdy_q && !txempty_q, "data write left TxRDY set")

	// an internal reset command returns to awaiting the mode byte
	`ASSERT_CLK(a_irst_mode, clk, arst_n, advance && in_word_s1.mode == MODE_CTRL_WR && !awaiting_mode_q && in_word_s1.data_byte[CMD_IRST] |=> awaiting_mode_q && !brk_q, "internal reset not taken")

endmodule
